### design/vpst_pkg.sv
// ----------------------------------------------------------------------------
// vpst_pkg
// shared types and constants for the video port and scanline timing block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpst_pkg;

  typedef enum logic [2:0] {
    OP_CTRL_WR  = 3'd0,
    OP_DATA_WR  = 3'd1,
    OP_DATA_RD  = 3'd2,
    OP_STAT_RD  = 3'd3,
    OP_SCANLINE = 3'd4,
    OP_FRAME    = 3'd5,
    OP_REG_RD   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ACC_NONE     = 3'd0,
    ACC_VRAM_RD  = 3'd1,
    ACC_VRAM_WR  = 3'd2,
    ACC_CRAM_WR  = 3'd3,
    ACC_VSRAM_WR = 3'd4
  } acc_e;

  typedef enum logic [1:0] {
    CMD_VRAM_RD = 2'd0,
    CMD_VRAM_WR = 2'd1,
    CMD_REG_WR  = 2'd2,
    CMD_CSRAM   = 2'd3
  } code_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic take;
    logic capture;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
  } sts_t;

  localparam logic [4:0] R_MODE1 = 5'd0;
  localparam logic [4:0] R_MODE2 = 5'd1;
  localparam logic [4:0] R_HLINE = 5'd10;
  localparam logic [4:0] R_MODE4 = 5'd12;
  localparam logic [4:0] R_STEP  = 5'd15;

  localparam logic [8:0] LINES_NTSC    = 9'd262;
  localparam logic [8:0] LINES_PAL     = 9'd313;
  localparam logic [8:0] LINES_ACTIVE  = 9'd224;
  localparam logic [8:0] H_LAST        = 9'd341;
  localparam logic [8:0] H_BLANK_START = 9'd320;

  localparam logic [15:0] STATUS_RESET = 16'h3400;
  localparam int          ST_HINT_BIT  = 2;
  localparam int          ST_VBL_BIT   = 3;
  localparam int          ST_COLL_BIT  = 9;

  localparam logic [11:0] CRAM_MASK  = 12'hEEE;
  localparam logic [9:0]  VSRAM_MASK = 10'h3FF;
  localparam logic [15:0] CRAM_ADDR_MASK  = 16'h007F;
  localparam logic [15:0] VSRAM_ADDR_MASK = 16'h003F;

endpackage

### design/vpst_if.sv
// ----------------------------------------------------------------------------
// vpst_req_if / vpst_rsp_if
// valid/ready channels for host requests and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vpst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] word;
  modport source (output valid, output op, output word, input ready);
  modport sink   (input valid, input op, input word, output ready);
endinterface

interface vpst_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [8:0]  line_number;
  logic        vblank_now;
  logic        hblank_now;
  logic        active_line_request;
  logic [4:0]  mode_summary;
  logic        mode5_flag;
  logic [1:0]  interlace_mode;
  modport source (output valid, output read_value, output line_number, output vblank_now,
                  output hblank_now, output active_line_request, output mode_summary,
                  output mode5_flag, output interlace_mode, input ready);
  modport sink   (input valid, input read_value, input line_number, input vblank_now,
                  input hblank_now, input active_line_request, input mode_summary,
                  input mode5_flag, input interlace_mode, output ready);
endinterface

### design/video_port_and_scanline_timing.sv
// ----------------------------------------------------------------------------
// video_port_and_scanline_timing
// host control/data ports and line timing of a video display processor
// ----------------------------------------------------------------------------
// After reset the block sweeps video memory to zero, one 16-bit word per cycle,
// through all VRAM_BYTES/2 words, and takes no request until that is done. A
// request's result is held until the sink takes it; a data read first passes a
// read state that waits on the registered video memory read port. One request is
// in flight at a time. Video memory must be a power of two in size, as must the
// color and scroll tables. The line mode register may be written at any time and
// acts on the next scanline request.
`timescale 1ns / 1ps

module video_port_and_scanline_timing #(
  parameter int VRAM_BYTES  = 65536,
  parameter int CRAM_WORDS  = 64,
  parameter int VSRAM_WORDS = 32,
  parameter int REG_COUNT   = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  vpst_req_if.sink  req_i,
  vpst_rsp_if.source rsp_o
);

  logic           pal_q;
  vpst_pkg::cmd_t cmd;
  vpst_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= 1'b0;
    end else if (cfg_we_i) begin
      pal_q <= cfg_wdata_i;
    end
  end

  vpst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vpst_dp #(
    .VRAM_BYTES  (VRAM_BYTES),
    .CRAM_WORDS  (CRAM_WORDS),
    .VSRAM_WORDS (VSRAM_WORDS),
    .REG_COUNT   (REG_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pal_i          (pal_q),
    .op_i           (req_i.op),
    .word_i         (req_i.word),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .read_value_o   (rsp_o.read_value),
    .line_number_o  (rsp_o.line_number),
    .vblank_o       (rsp_o.vblank_now),
    .hblank_o       (rsp_o.hblank_now),
    .active_o       (rsp_o.active_line_request),
    .mode_summary_o (rsp_o.mode_summary),
    .mode5_o        (rsp_o.mode5_flag),
    .interlace_o    (rsp_o.interlace_mode)
  );

endmodule

### design/vpst_ctrl.sv
// ----------------------------------------------------------------------------
// vpst_ctrl
// sequencer: vram clearing, request accept, read wait and result hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vpst_pkg::sts_t sts_i,
  output vpst_pkg::cmd_t cmd_o
);

  vpst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vpst_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      vpst_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = vpst_pkg::ST_IDLE;
      end
      vpst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = sts_i.is_read ? vpst_pkg::ST_READ : vpst_pkg::ST_RESP;
        end
      end
      vpst_pkg::ST_READ: begin
        cmd_o.capture = 1'b1;
        state_d = vpst_pkg::ST_RESP;
      end
      vpst_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = vpst_pkg::ST_IDLE;
      end
      default: state_d = vpst_pkg::ST_CLEAR;
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before taken");

  a_read_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("read capture not followed by result");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_step |-> !in_ready_o && !out_valid_o)
    else $error("handshake during clearing pass");

endmodule

### design/vpst_dp.sv
// ----------------------------------------------------------------------------
// vpst_dp
// datapath: port state, registers, line timing and video/color/scroll memories
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpst_dp #(
  parameter int VRAM_BYTES  = 65536,
  parameter int CRAM_WORDS  = 64,
  parameter int VSRAM_WORDS = 32,
  parameter int REG_COUNT   = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pal_i,
  input  logic [2:0]     op_i,
  input  logic [15:0]    word_i,
  input  vpst_pkg::cmd_t cmd_i,
  output vpst_pkg::sts_t sts_o,
  output logic [15:0]    read_value_o,
  output logic [8:0]     line_number_o,
  output logic           vblank_o,
  output logic           hblank_o,
  output logic           active_o,
  output logic [4:0]     mode_summary_o,
  output logic           mode5_o,
  output logic [1:0]     interlace_o
);

  localparam int VramWords = VRAM_BYTES / 2;
  localparam int VAW = $clog2(VramWords);
  localparam int CAW = $clog2(CRAM_WORDS);
  localparam int SAW = $clog2(VSRAM_WORDS);
  localparam int RAW = $clog2(REG_COUNT);

  logic [7:0]  regs_q [REG_COUNT];
  logic [15:0] status_q;
  vpst_pkg::acc_e kind_q;
  logic [15:0] addr_q;
  logic        pend_q;
  logic [15:0] first_q;
  logic [7:0]  step_q;
  logic [8:0]  vcnt_q, hcnt_q;
  logic        vblank_q, hblank_q;
  logic [7:0]  hcd_q, hreload_q;
  logic        hint_en_q, vint_en_q, mode5_q;
  logic [1:0]  ilace_q;
  logic [15:0] rv_q;
  logic        active_q, rd_hit_q, rd_swap_q;
  logic [VAW:0] clr_q;

  logic [15:0] vram [VramWords];
  logic [11:0] cram [CRAM_WORDS];
  logic [9:0]  vsram [VSRAM_WORDS];
  logic [15:0] vram_rd_q;

  vpst_pkg::op_e op;
  logic [15:0] addr_next;
  logic [15:0] cmd_addr;
  logic [4:0]  wr_idx;
  logic [7:0]  rd_idx;

  // scanline next values
  logic [15:0] sl_status;
  logic [8:0]  sl_vcnt, sl_hcnt, frame_lines;
  logic        sl_vblank, sl_hblank, sl_active;
  logic [7:0]  sl_hcd;

  logic           vram_we;
  logic [VAW-1:0] vram_waddr;
  logic [15:0]    vram_wdata;

  assign op        = vpst_pkg::op_e'(op_i);
  assign addr_next = addr_q + {8'd0, step_q};
  assign cmd_addr  = {word_i[1:0] | first_q[15:14], first_q[13:0]};
  assign wr_idx    = word_i[4:0];
  assign rd_idx    = word_i[7:0];
  assign frame_lines = pal_i ? vpst_pkg::LINES_PAL : vpst_pkg::LINES_NTSC;

  assign sts_o.clear_last = (clr_q == (VAW+1)'(VramWords - 1));
  assign sts_o.is_read    = (op == vpst_pkg::OP_DATA_RD);

  always_comb begin
    sl_status = status_q;
    sl_vblank = vblank_q;
    sl_hblank = hblank_q;
    sl_hcd    = hcd_q;
    sl_active = 1'b0;
    if (vcnt_q < vpst_pkg::LINES_ACTIVE) begin
      sl_active = 1'b1;
      if (hint_en_q) begin
        if (hcd_q == 8'd0) begin
          sl_status[vpst_pkg::ST_HINT_BIT] = 1'b1;
          sl_hcd = hreload_q;
        end else begin
          sl_hcd = hcd_q - 8'd1;
        end
      end
    end else if (vcnt_q == vpst_pkg::LINES_ACTIVE) begin
      sl_vblank = 1'b1;
      sl_status[vpst_pkg::ST_VBL_BIT] = 1'b1;
    end
    sl_vcnt = vcnt_q + 9'd1;
    if (sl_vcnt >= frame_lines) begin
      sl_vcnt = 9'd0;
      sl_vblank = 1'b0;
      sl_status[vpst_pkg::ST_VBL_BIT] = 1'b0;
    end
    sl_hcnt = (hcnt_q == vpst_pkg::H_LAST) ? 9'd0 : hcnt_q + 9'd1;
    if (sl_hcnt == vpst_pkg::H_BLANK_START) begin
      sl_hblank = 1'b1;
      sl_status[vpst_pkg::ST_HINT_BIT] = 1'b1;
    end else if (sl_hcnt == 9'd0) begin
      sl_hblank = 1'b0;
      sl_status[vpst_pkg::ST_HINT_BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= 8'd0;
      status_q  <= vpst_pkg::STATUS_RESET;
      kind_q    <= vpst_pkg::ACC_NONE;
      addr_q    <= 16'd0;
      pend_q    <= 1'b0;
      first_q   <= 16'd0;
      step_q    <= 8'd1;
      vcnt_q    <= 9'd0;
      hcnt_q    <= 9'd0;
      vblank_q  <= 1'b1;
      hblank_q  <= 1'b0;
      hcd_q     <= 8'd0;
      hreload_q <= 8'd0;
      hint_en_q <= 1'b0;
      vint_en_q <= 1'b0;
      mode5_q   <= 1'b1;
      ilace_q   <= 2'd0;
      active_q  <= 1'b0;
      rd_hit_q  <= 1'b0;
      rd_swap_q <= 1'b0;
      rv_q      <= 16'd0;
      clr_q     <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.capture) begin
        rv_q <= !rd_hit_q ? 16'd0 :
                rd_swap_q ? {vram_rd_q[7:0], vram_rd_q[15:8]} : vram_rd_q;
      end
      if (cmd_i.take) begin
        rv_q     <= 16'd0;
        active_q <= 1'b0;
        unique case (op)
          vpst_pkg::OP_CTRL_WR: begin
            if (!pend_q) begin
              first_q <= word_i;
              pend_q  <= 1'b1;
            end else begin
              pend_q <= 1'b0;
              unique case (vpst_pkg::code_e'(word_i[15:14]))
                vpst_pkg::CMD_VRAM_RD: begin
                  kind_q <= vpst_pkg::ACC_VRAM_RD;
                  addr_q <= cmd_addr;
                end
                vpst_pkg::CMD_VRAM_WR: begin
                  kind_q <= vpst_pkg::ACC_VRAM_WR;
                  addr_q <= cmd_addr;
                end
                vpst_pkg::CMD_REG_WR: begin
                  if (int'(wr_idx) < REG_COUNT) begin
                    regs_q[wr_idx[RAW-1:0]] <= first_q[7:0];
                    unique case (wr_idx)
                      vpst_pkg::R_MODE1: hint_en_q <= first_q[4];
                      vpst_pkg::R_MODE2: begin
                        vint_en_q <= first_q[5];
                        mode5_q   <= first_q[2];
                      end
                      vpst_pkg::R_HLINE: hreload_q <= first_q[7:0];
                      vpst_pkg::R_MODE4: ilace_q   <= first_q[2:1];
                      vpst_pkg::R_STEP:  step_q    <= first_q[7:0];
                      default: ;
                    endcase
                  end
                end
                vpst_pkg::CMD_CSRAM: begin
                  if (word_i[7]) begin
                    kind_q <= vpst_pkg::ACC_VSRAM_WR;
                    addr_q <= cmd_addr & vpst_pkg::VSRAM_ADDR_MASK;
                  end else begin
                    kind_q <= vpst_pkg::ACC_CRAM_WR;
                    addr_q <= cmd_addr & vpst_pkg::CRAM_ADDR_MASK;
                  end
                end
                default: ;
              endcase
            end
          end
          vpst_pkg::OP_DATA_WR: addr_q <= addr_next;
          vpst_pkg::OP_DATA_RD: begin
            addr_q    <= addr_next;
            rd_hit_q  <= (kind_q == vpst_pkg::ACC_VRAM_RD);
            rd_swap_q <= addr_q[0];
          end
          vpst_pkg::OP_STAT_RD: begin
            rv_q <= status_q;
            status_q[vpst_pkg::ST_COLL_BIT] <= 1'b0;
          end
          vpst_pkg::OP_SCANLINE: begin
            status_q <= sl_status;
            vcnt_q   <= sl_vcnt;
            hcnt_q   <= sl_hcnt;
            vblank_q <= sl_vblank;
            hblank_q <= sl_hblank;
            hcd_q    <= sl_hcd;
            active_q <= sl_active;
          end
          vpst_pkg::OP_FRAME: begin
            status_q[vpst_pkg::ST_HINT_BIT] <= 1'b0;
            status_q[vpst_pkg::ST_VBL_BIT]  <= 1'b0;
            hcd_q <= hreload_q;
            if (regs_q[vpst_pkg::R_MODE2][2]) mode5_q <= 1'b1;
          end
          vpst_pkg::OP_REG_RD: begin
            rv_q <= (int'(rd_idx) < REG_COUNT) ? {8'd0, regs_q[rd_idx[RAW-1:0]]} : 16'd0;
          end
          default: ;
        endcase
      end
    end
  end

  // vram holds byte pairs; odd addresses see the pair swapped
  assign vram_we    = cmd_i.clear_step ||
                      (cmd_i.take && op == vpst_pkg::OP_DATA_WR &&
                       kind_q == vpst_pkg::ACC_VRAM_WR);
  assign vram_waddr = cmd_i.clear_step ? clr_q[VAW-1:0] : addr_q[VAW:1];
  assign vram_wdata = cmd_i.clear_step ? 16'd0 :
                      addr_q[0] ? {word_i[7:0], word_i[15:8]} : word_i;

  always_ff @(posedge clk_i) begin
    if (vram_we) vram[vram_waddr] <= vram_wdata;
    if (cmd_i.take) vram_rd_q <= vram[addr_q[VAW:1]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && op == vpst_pkg::OP_DATA_WR) begin
      if (kind_q == vpst_pkg::ACC_CRAM_WR)
        cram[addr_q[CAW:1]] <= word_i[11:0] & vpst_pkg::CRAM_MASK;
      if (kind_q == vpst_pkg::ACC_VSRAM_WR)
        vsram[addr_q[SAW:1]] <= word_i[9:0] & vpst_pkg::VSRAM_MASK;
    end
  end

  assign read_value_o   = rv_q;
  assign line_number_o  = vcnt_q;
  assign vblank_o       = vblank_q;
  assign hblank_o       = hblank_q;
  assign active_o       = active_q;
  assign mode5_o        = mode5_q;
  assign interlace_o    = ilace_q;
  assign mode_summary_o = {regs_q[vpst_pkg::R_MODE4][3],
                           |regs_q[vpst_pkg::R_MODE4][2:1],
                           regs_q[vpst_pkg::R_MODE4][0],
                           regs_q[vpst_pkg::R_MODE2][2],
                           regs_q[vpst_pkg::R_MODE1][2]};

endmodule
